/* hw/rtl/urv_pkg.sv */
`default_nettype none

package urv_pkg;

    // field and counter widths
    localparam int ECHO_BITS     = 16;
    localparam int INTERVAL_BITS = 32;
    localparam int TRIG_BITS     = 8;
    localparam int DIST_BITS     = 11;
    localparam int SPEED_BITS    = 16;
    localparam int SCALE_BITS    = 14;

    localparam logic [TRIG_BITS-1:0]  TRIG_RESET  = 8'd10;
    localparam logic [SCALE_BITS-1:0] SPEED_SCALE = 14'd10000;
    localparam logic [DIST_BITS-1:0]  DIST_MAX    = 11'd2047;
    localparam logic [SPEED_BITS-1:0] SPEED_MAX   = 16'hFFFF;

    // width / 58 by reciprocal multiply, exact over the whole echo range
    localparam int CM_DIVISOR  = 58;
    localparam int RECIP_SHIFT = ECHO_BITS + 6;
    localparam int RECIP_BITS  = ECHO_BITS + 1;
    localparam logic [RECIP_BITS-1:0] RECIP_MUL =
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'(CM_DIVISOR - 1)) / 64'(CM_DIVISOR));
    localparam int PROD_BITS = ECHO_BITS + RECIP_BITS;
    localparam int QUOT_BITS = PROD_BITS - RECIP_SHIFT;
    localparam int DIST_EXT  = (QUOT_BITS > DIST_BITS) ? QUOT_BITS : DIST_BITS;

    // speed numerator and iterative divider
    localparam int NUM_BITS     = DIST_BITS + SCALE_BITS;
    localparam int DIV_CNT_BITS = $clog2(NUM_BITS + 1);

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        PH_TRIGGER = 2'd0,
        PH_WAIT    = 2'd1,
        PH_HIGH    = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        BK_IDLE   = 3'd0,
        BK_SCALE  = 3'd1,
        BK_DELTA  = 3'd2,
        BK_WEIGHT = 3'd3,
        BK_DIVIDE = 3'd4,
        BK_HOLD   = 3'd5
    } back_state_t;

    // one classified tick
    typedef struct packed {
        logic                     trig;
        logic                     done;
        logic [ECHO_BITS-1:0]     width;
        logic [INTERVAL_BITS-1:0] interval;
    } urv_rec_t;

endpackage

`default_nettype wire

/* hw/rtl/ultrasonic_range_velocity_core.sv */
// channel   direction  handshake              payload
// input     in         in_valid / in_stall    echo_level
// output    out        out_valid / out_stall  trigger_level measure_done distance_cm
//                                             change_cm speed_value speed_valid
// config    in         cfg_wr_en              cfg_wr_data (trigger_ticks)
//
// one result transaction per input transaction, in order
// ticks with no completion go straight to the output register once the output is free and the back is idle
// a completing tick goes through the back in steps: reciprocal multiply,
//   difference, scale multiply, then (but for the first measurement) a one-bit-per-cycle divider
// a 4 entry queue holds classified ticks; in_stall rises only when it is full
// rst_n is asynchronous active low; it clears phase, counters and history
`default_nettype none

module ultrasonic_range_velocity_core
    import urv_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration
    input  wire logic                 cfg_wr_en,
    input  wire logic [TRIG_BITS-1:0] cfg_wr_data,
    // input channel
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 echo_level,
    // output channel
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      trigger_level,
    output logic                      measure_done,
    output logic [DIST_BITS-1:0]      distance_cm,
    output logic [DIST_BITS-1:0]      change_cm,
    output logic [SPEED_BITS-1:0]     speed_value,
    output logic                      speed_valid
);

    urv_rec_t front_rec;
    urv_rec_t head_rec;
    logic     q_full;
    logic     q_empty;
    logic     q_pop;
    logic     in_accept;

    // the front advances only when the queue can take the record
    assign in_stall  = q_full;
    assign in_accept = in_valid && !q_full;

    // front: trigger pulse, echo wait, echo width and interval counting
    urv_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (in_accept),
        .echo_level  (echo_level),
        .rec         (front_rec)
    );

    // short queue of classified ticks
    urv_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_accept),
        .push_rec (front_rec),
        .full     (q_full),
        .pop      (q_pop),
        .head_rec (head_rec),
        .empty    (q_empty)
    );

    // back: distance, change, speed and the output register
    urv_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_rec      (head_rec),
        .empty         (q_empty),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .trigger_level (trigger_level),
        .measure_done  (measure_done),
        .distance_cm   (distance_cm),
        .change_cm     (change_cm),
        .speed_value   (speed_value),
        .speed_valid   (speed_valid)
    );

endmodule

`default_nettype wire

/* hw/rtl/urv_front.sv */
`default_nettype none

module urv_front
    import urv_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [TRIG_BITS-1:0] cfg_wr_data,
    input  wire logic                 accept,
    input  wire logic                 echo_level,
    output urv_rec_t                  rec
);

    localparam logic [ECHO_BITS-1:0]     EMAX = '1;
    localparam logic [INTERVAL_BITS-1:0] IMAX = '1;

    logic [TRIG_BITS-1:0]     trig_ticks_reg;
    phase_t                   phase_reg, phase_next;
    logic [TRIG_BITS-1:0]     count_reg, count_next;
    logic [ECHO_BITS-1:0]     width_reg, width_next;
    logic [INTERVAL_BITS-1:0] interval_reg, interval_next;

    logic [TRIG_BITS-1:0]     trig_len;
    logic [TRIG_BITS-1:0]     count_inc;
    logic                     trig_end;
    logic [INTERVAL_BITS-1:0] interval_inc;

    assign trig_len     = (trig_ticks_reg == '0) ? TRIG_BITS'(1) : trig_ticks_reg;
    assign count_inc    = count_reg + TRIG_BITS'(1);
    assign trig_end     = (count_inc >= trig_len) || (count_inc == '0);
    assign interval_inc = (interval_reg == IMAX) ? interval_reg
                                                 : interval_reg + INTERVAL_BITS'(1);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_WAIT:
            begin
                if (echo_level)
                    phase_next = PH_HIGH;
            end
            PH_HIGH:
            begin
                if (!echo_level)
                    phase_next = PH_TRIGGER;
            end
            default:
            begin
                phase_next = trig_end ? PH_WAIT : PH_TRIGGER;
            end
        endcase
    end

    // record and counters
    always_comb
    begin
        rec.trig      = 1'b0;
        rec.done      = 1'b0;
        rec.width     = width_reg;
        rec.interval  = interval_inc;
        count_next    = count_reg;
        width_next    = width_reg;
        interval_next = interval_inc;
        case (phase_reg)
            PH_WAIT:
            begin
                if (echo_level)
                    width_next = ECHO_BITS'(1);
            end
            PH_HIGH:
            begin
                if (echo_level)
                begin
                    if (width_reg != EMAX)
                        width_next = width_reg + ECHO_BITS'(1);
                end
                else
                begin
                    rec.done      = 1'b1;
                    width_next    = '0;
                    count_next    = '0;
                    interval_next = '0;
                end
            end
            default:
            begin
                rec.trig   = 1'b1;
                count_next = trig_end ? '0 : count_inc;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_ticks_reg <= TRIG_RESET;
            phase_reg      <= PH_TRIGGER;
            count_reg      <= '0;
            width_reg      <= '0;
            interval_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                trig_ticks_reg <= cfg_wr_data;
            if (accept)
            begin
                phase_reg    <= phase_next;
                count_reg    <= count_next;
                width_reg    <= width_next;
                interval_reg <= interval_next;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/urv_queue.sv */
`default_nettype none

module urv_queue
    import urv_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  urv_rec_t  push_rec,
    output logic      full,
    input  wire logic pop,
    output urv_rec_t  head_rec,
    output logic      empty
);

    urv_rec_t            entry_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   fill_reg, fill_next;
    logic                do_push, do_pop;

    assign full     = (fill_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_rec = entry_mem[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + (QUEUE_AW+1)'(1);
        else if (do_pop && !do_push)
            fill_next = fill_reg - (QUEUE_AW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_mem[wr_ptr_reg] <= push_rec;
    end

endmodule

`default_nettype wire

/* hw/rtl/urv_div.sv */
`default_nettype none

module urv_div
    import urv_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [NUM_BITS-1:0]      num,
    input  wire logic [INTERVAL_BITS-1:0] den,
    output logic                          done,
    output logic [NUM_BITS-1:0]           quo
);

    logic                     busy_reg;
    logic                     done_reg;
    logic [DIV_CNT_BITS-1:0]  cnt_reg;
    logic [INTERVAL_BITS-1:0] rem_reg;
    logic [INTERVAL_BITS-1:0] den_reg;
    logic [NUM_BITS-1:0]      quo_reg;

    logic [INTERVAL_BITS:0]   trial;
    logic [INTERVAL_BITS:0]   diff;
    logic                     fits;

    // restoring division, one quotient bit a cycle
    assign trial = {rem_reg, quo_reg[NUM_BITS-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});
    assign done  = done_reg;
    assign quo   = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_BITS'(NUM_BITS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - DIV_CNT_BITS'(1);
            if (cnt_reg == DIV_CNT_BITS'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[INTERVAL_BITS-1:0] : trial[INTERVAL_BITS-1:0];
            quo_reg <= {quo_reg[NUM_BITS-2:0], fits};
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/urv_back.sv */
`default_nettype none

module urv_back
    import urv_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  urv_rec_t                   head_rec,
    input  wire logic                  empty,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       trigger_level,
    output logic                       measure_done,
    output logic [DIST_BITS-1:0]       distance_cm,
    output logic [DIST_BITS-1:0]       change_cm,
    output logic [SPEED_BITS-1:0]      speed_value,
    output logic                       speed_valid
);

    back_state_t state_reg, state_next;

    logic                     out_free;
    logic                     load_tick;
    logic                     load_meas;
    logic                     div_start;
    logic                     div_done;
    logic [NUM_BITS-1:0]      div_quo;

    logic [ECHO_BITS-1:0]     width_reg;
    logic [INTERVAL_BITS-1:0] interval_reg;
    logic [PROD_BITS-1:0]     prod_reg;
    logic [DIST_BITS-1:0]     dist_reg;
    logic [DIST_BITS-1:0]     chg_reg;
    logic [NUM_BITS-1:0]      num_prod;
    logic                     first_reg;
    logic [SPEED_BITS-1:0]    speed_reg;
    logic                     svalid_reg;
    logic [DIST_BITS-1:0]     last_dist_reg;
    logic                     have_prev_reg;

    logic                     out_valid_reg;
    logic                     out_trig_reg;
    logic                     out_done_reg;
    logic [DIST_BITS-1:0]     out_dist_reg;
    logic [DIST_BITS-1:0]     out_chg_reg;
    logic [SPEED_BITS-1:0]    out_speed_reg;
    logic                     out_svalid_reg;

    logic [DIST_EXT-1:0]      quot_ext;
    logic [DIST_BITS-1:0]     dist_sat;
    logic [DIST_BITS-1:0]     chg_abs;
    logic [SPEED_BITS-1:0]    speed_sat;

    assign out_free = !out_valid_reg || !out_stall;

    assign quot_ext  = DIST_EXT'(prod_reg[PROD_BITS-1:RECIP_SHIFT]);
    assign dist_sat  = (quot_ext > DIST_EXT'(DIST_MAX)) ? DIST_MAX : quot_ext[DIST_BITS-1:0];
    assign chg_abs   = (dist_sat > last_dist_reg) ? dist_sat - last_dist_reg
                                                  : last_dist_reg - dist_sat;
    assign speed_sat = (div_quo > NUM_BITS'(SPEED_MAX)) ? SPEED_MAX
                                                        : div_quo[SPEED_BITS-1:0];

    // speed numerator from the registered change, taken by the divider at start
    assign num_prod  = NUM_BITS'(chg_reg) * NUM_BITS'(SPEED_SCALE);

    urv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_prod),
        .den   (interval_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!empty && head_rec.done)
                    state_next = BK_SCALE;
            end
            BK_SCALE:  state_next = BK_DELTA;
            BK_DELTA:  state_next = BK_WEIGHT;
            BK_WEIGHT: state_next = first_reg ? BK_HOLD : BK_DIVIDE;
            BK_DIVIDE:
            begin
                if (div_done)
                    state_next = BK_HOLD;
            end
            BK_HOLD:
            begin
                if (out_free)
                    state_next = BK_IDLE;
            end
            default:   state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        load_tick = 1'b0;
        load_meas = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    pop       = head_rec.done || out_free;
                    load_tick = !head_rec.done && out_free;
                end
            end
            BK_WEIGHT: div_start = !first_reg;
            BK_HOLD:   load_meas = out_free;
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            last_dist_reg <= '0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_DELTA)
            begin
                last_dist_reg <= dist_sat;
                have_prev_reg <= 1'b1;
            end
            if (load_tick || load_meas)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // measurement datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == BK_IDLE && pop && head_rec.done)
        begin
            width_reg    <= head_rec.width;
            interval_reg <= head_rec.interval;
        end
        if (state_reg == BK_SCALE)
            prod_reg <= PROD_BITS'(width_reg) * PROD_BITS'(RECIP_MUL);
        if (state_reg == BK_DELTA)
        begin
            dist_reg  <= dist_sat;
            chg_reg   <= chg_abs;
            first_reg <= !have_prev_reg;
        end
        if (state_reg == BK_WEIGHT)
        begin
            speed_reg  <= '0;
            svalid_reg <= 1'b0;
        end
        if (state_reg == BK_DIVIDE && div_done)
        begin
            speed_reg  <= speed_sat;
            svalid_reg <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (load_tick)
        begin
            out_trig_reg   <= head_rec.trig;
            out_done_reg   <= 1'b0;
            out_dist_reg   <= '0;
            out_chg_reg    <= '0;
            out_speed_reg  <= '0;
            out_svalid_reg <= 1'b0;
        end
        else if (load_meas)
        begin
            out_trig_reg   <= 1'b0;
            out_done_reg   <= 1'b1;
            out_dist_reg   <= dist_reg;
            out_chg_reg    <= chg_reg;
            out_speed_reg  <= speed_reg;
            out_svalid_reg <= svalid_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign trigger_level = out_trig_reg;
    assign measure_done  = out_done_reg;
    assign distance_cm   = out_dist_reg;
    assign change_cm     = out_chg_reg;
    assign speed_value   = out_speed_reg;
    assign speed_valid   = out_svalid_reg;

endmodule

`default_nettype wire

/* hw/rtl/urv_checker.sv */
`default_nettype none

module urv_checker
    import urv_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic                  trigger_level,
    input wire logic                  measure_done,
    input wire logic [DIST_BITS-1:0]  distance_cm,
    input wire logic [DIST_BITS-1:0]  change_cm,
    input wire logic [SPEED_BITS-1:0] speed_value,
    input wire logic                  speed_valid
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(distance_cm) && $stable(change_cm)
            && $stable(speed_value) && $stable(measure_done) && $stable(trigger_level))
        else $error("stalled result changed");

    // trigger is never driven on a completing tick
    a_done_no_trig: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && measure_done |-> !trigger_level)
        else $error("trigger high on completion");

    // non-completing ticks carry zero measurement fields
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !measure_done |-> distance_cm == '0 && change_cm == '0
            && speed_value == '0 && !speed_valid)
        else $error("measurement fields set without completion");

    // a completion without a valid speed reports zero speed
    a_first_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && measure_done && !speed_valid |-> speed_value == '0)
        else $error("speed set while invalid");

endmodule

bind ultrasonic_range_velocity_core urv_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .trigger_level (trigger_level),
    .measure_done  (measure_done),
    .distance_cm   (distance_cm),
    .change_cm     (change_cm),
    .speed_value   (speed_value),
    .speed_valid   (speed_valid)
);

`default_nettype wire

/* tb/sv/tb_ultrasonic_range_velocity_core.sv */
`timescale 1ns / 100ps

module tb_ultrasonic_range_velocity_core;
    import urv_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 200_000;
    // margin for the back end after the last result; queue holds 4
    localparam int DRAIN_CYCLES = 160;

    // one expected result transaction
    typedef struct {
        logic                  trigger_level;
        logic                  measure_done;
        logic [DIST_BITS-1:0]  distance_cm;
        logic [DIST_BITS-1:0]  change_cm;
        logic [SPEED_BITS-1:0] speed_value;
        logic                  speed_valid;
    } tick_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [TRIG_BITS-1:0]  cfg_wr_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  echo_level;
    logic                  out_valid;
    logic                  out_stall;
    logic                  trigger_level;
    logic                  measure_done;
    logic [DIST_BITS-1:0]  distance_cm;
    logic [DIST_BITS-1:0]  change_cm;
    logic [SPEED_BITS-1:0] speed_value;
    logic                  speed_valid;

    ultrasonic_range_velocity_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .echo_level    (echo_level),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .trigger_level (trigger_level),
        .measure_done  (measure_done),
        .distance_cm   (distance_cm),
        .change_cm     (change_cm),
        .speed_value   (speed_value),
        .speed_valid   (speed_valid)
    );

    // ranger state as the testbench sees it
    logic [TRIG_BITS-1:0]     pulse_len_reg;
    phase_t                   ranger_phase;
    logic [TRIG_BITS-1:0]     pulse_count;
    logic [ECHO_BITS-1:0]     echo_ticks;
    logic [INTERVAL_BITS-1:0] ticks_since_done;
    logic [DIST_BITS-1:0]     prev_distance;
    logic                     have_prev;

    // expected result transactions, oldest first
    tick_result_t expected_ticks[$];

    int unsigned error_count;
    int unsigned live_ticks;     // ticks outside the trigger pulse
    int unsigned completions;
    int unsigned send_gap_pct;
    int unsigned recv_stall_pct;
    int unsigned cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor: one call per accepted tick, pushes the expected result
    // ------------------------------------------------------------------
    task automatic ranger_reset();
        pulse_len_reg    = TRIG_RESET;
        ranger_phase     = PH_TRIGGER;
        pulse_count      = '0;
        echo_ticks       = '0;
        ticks_since_done = '0;
        prev_distance    = '0;
        have_prev        = 1'b0;
    endtask

    task automatic range_tick(input logic echo);
        tick_result_t         res;
        int unsigned          range_cm;
        logic [DIST_BITS-1:0] delta;
        logic [63:0]          quo;
        logic [TRIG_BITS-1:0] len;
        res = '{default: '0};
        // interval counts every tick, including the completing one
        if (ticks_since_done != '1)
            ticks_since_done = ticks_since_done + 1'b1;
        if (ranger_phase != PH_TRIGGER)
            live_ticks++;
        case (ranger_phase)
            PH_WAIT:
            begin
                // the rising tick already counts as one
                if (echo)
                begin
                    echo_ticks   = ECHO_BITS'(1);
                    ranger_phase = PH_HIGH;
                end
            end
            PH_HIGH:
            begin
                if (echo)
                begin
                    if (echo_ticks != '1)
                        echo_ticks = echo_ticks + 1'b1;
                end
                else
                begin
                    range_cm = 32'(echo_ticks) / CM_DIVISOR;
                    if (range_cm > DIST_MAX)
                        range_cm = DIST_MAX;
                    res.distance_cm = DIST_BITS'(range_cm);
                    delta = (res.distance_cm > prev_distance)
                          ? res.distance_cm - prev_distance
                          : prev_distance - res.distance_cm;
                    res.change_cm = delta;
                    // first measurement after reset has no speed
                    if (have_prev)
                    begin
                        quo = (ticks_since_done == '0) ? 64'(SPEED_MAX)
                            : 64'(delta) * 64'(SPEED_SCALE) / 64'(ticks_since_done);
                        if (quo > 64'(SPEED_MAX))
                            quo = 64'(SPEED_MAX);
                        res.speed_value = SPEED_BITS'(quo);
                        res.speed_valid = 1'b1;
                    end
                    res.measure_done = 1'b1;
                    prev_distance    = res.distance_cm;
                    have_prev        = 1'b1;
                    ticks_since_done = '0;
                    echo_ticks       = '0;
                    pulse_count      = '0;
                    ranger_phase     = PH_TRIGGER;
                    completions++;
                end
            end
            default:
            begin
                // zero length acts as one; echo ignored while triggering
                len = (pulse_len_reg == '0) ? TRIG_BITS'(1) : pulse_len_reg;
                res.trigger_level = 1'b1;
                pulse_count = pulse_count + 1'b1;
                if (pulse_count >= len || pulse_count == '0)
                begin
                    pulse_count  = '0;
                    ranger_phase = PH_WAIT;
                end
                else
                begin
                    ranger_phase = PH_TRIGGER;
                end
            end
        endcase
        expected_ticks.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // input side: one transaction per tick, driven at the falling edge
    // ------------------------------------------------------------------
    task automatic send_tick(input logic echo);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        echo_level <= echo;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        range_tick(echo);
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_ticks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // register writes only once the block has gone quiet
    task automatic write_pulse_len(input logic [TRIG_BITS-1:0] len);
        wait_results_drained();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        pulse_len_reg = len;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // finish the pulse with random echo, wait gap ticks, then an echo of width ticks
    task automatic measure_echo(input int unsigned gap, input int unsigned width);
        while (ranger_phase == PH_TRIGGER)
            send_tick(1'($urandom_range(1)));
        repeat (gap) send_tick(1'b0);
        repeat (width) send_tick(1'b1);
        send_tick(1'b0);
    endtask

    task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
        send_gap_pct   = sender_pct;
        recv_stall_pct = receiver_pct;
    endtask

    // ------------------------------------------------------------------
    // output side: random stall, compare each result with the oldest
    // ------------------------------------------------------------------
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        tick_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_ticks.size() == 0)
            begin
                $error("result transaction with no tick pending");
                error_count++;
            end
            else
            begin
                exp_r = expected_ticks.pop_front();
                check_field("trigger_level", exp_r.trigger_level, trigger_level);
                check_field("measure_done", exp_r.measure_done, measure_done);
                check_field("distance_cm", exp_r.distance_cm, distance_cm);
                check_field("change_cm", exp_r.change_cm, change_cm);
                check_field("speed_value", exp_r.speed_value, speed_value);
                check_field("speed_valid", exp_r.speed_valid, speed_valid);
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset pulse length, first measurement has no speed, then equal distance
    task automatic test_first_measurement();
        measure_echo(3, 30);
        measure_echo(0, 30);
    endtask

    // widths around the 58 tick step, distance rising and falling
    task automatic test_distance_steps();
        measure_echo(1, 57);
        measure_echo(2, 58);
        measure_echo(1, 116);
        measure_echo(0, 1);
    endtask

    // shortest, longest and zero pulse length
    task automatic test_pulse_lengths();
        write_pulse_len(TRIG_BITS'(1));
        measure_echo(0, 60);
        write_pulse_len('1);
        measure_echo(2, 10);
        write_pulse_len('0);
        measure_echo(1, 20);
        measure_echo(0, 10);
    endtask

    // register lowered below the running count, then raised mid pulse
    task automatic test_pulse_change_mid_pulse();
        write_pulse_len(TRIG_BITS'(40));
        measure_echo(0, 10);
        repeat (20) send_tick(1'($urandom_range(1)));
        write_pulse_len(TRIG_BITS'(5));
        measure_echo(1, 58);
        write_pulse_len(TRIG_BITS'(4));
        measure_echo(0, 5);
        repeat (3) send_tick(1'($urandom_range(1)));
        write_pulse_len(TRIG_BITS'(12));
        measure_echo(0, 30);
    endtask

    // mostly well formed pulses with random content, some loose echo noise
    task automatic test_random_ranging(input int unsigned min_ticks, input int unsigned min_done);
        int unsigned start_live;
        int unsigned start_done;
        int unsigned pick;
        int unsigned gap;
        int unsigned width;
        start_live = live_ticks;
        start_done = completions;
        while (live_ticks - start_live < min_ticks || completions - start_done < min_done)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
            begin
                // noise: may cut an echo short or start one early
                repeat ($urandom_range(1, 12)) send_tick(1'($urandom_range(1)));
            end
            else
            begin
                gap = ($urandom_range(99) < 85) ? $urandom_range(0, 6)
                                                : $urandom_range(7, 60);
                pick = $urandom_range(99);
                width = (pick < 50) ? $urandom_range(1, 50)
                      : (pick < 90) ? $urandom_range(51, 120)
                                    : $urandom_range(121, 200);
                measure_echo(gap, width);
            end
        end
    endtask

    task automatic finish_run();
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("** ultrasonic_range_velocity_core: PASSED **");
        else
            $display("** ultrasonic_range_velocity_core: FAILED **");
        $finish;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        echo_level  = 1'b0;
        error_count = 0;
        live_ticks  = 0;
        completions = 0;
        ranger_reset();
        set_idling(8, 61);
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        test_first_measurement();
        test_distance_steps();
        test_pulse_lengths();
        test_pulse_change_mid_pulse();
        write_pulse_len(TRIG_BITS'($urandom_range(1, 16)));
        test_random_ranging(100, 2);

        set_idling(61, 8);
        write_pulse_len(TRIG_BITS'($urandom_range(1, 16)));
        test_random_ranging(100, 2);

        set_idling(0, 0);
        write_pulse_len(TRIG_BITS'($urandom_range(1, 16)));
        test_random_ranging(100, 2);

        finish_run();
    end

    // hang guard
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** ultrasonic_range_velocity_core: FAILED **");
        $finish;
    end

endmodule
